>>> rtl/core/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants of the point-in-polygon tester
// Table depth, item kinds, vertex and edge request types.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int SCAN_LAST    = MAX_VERTICES + 2;
    localparam int STEP_W       = $clog2(SCAN_LAST + 1);

    localparam int COORD_W = 24;
    localparam int OFS_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int D2_W    = SQ_W + 1;
    localparam int RAD_W   = 51;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_TEST = 2'd1;
    localparam logic [1:0] KIND_MOVE = 2'd2;

    typedef struct packed {
        logic signed [OFS_W-1:0] dx;
        logic signed [OFS_W-1:0] dy;
    } t_vertex;

    typedef struct packed {
        logic    valid;
        t_vertex vi;
        t_vertex vj;
    } t_edge_req;

endpackage

>>> rtl/core/point_in_polygon_tester_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_tester_top: even-odd point-in-polygon tester
// Keeps polygon vertices as offsets from a movable center in a ring of cells.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready) carries kind, pos_x, pos_y; one
// transaction is taken while the block is idle. Output channel
// (o_out_valid/i_out_ready) returns one result transaction per item.
// Add, move and unused kinds pass S_SQ, S_DEC and S_DONE before the result goes valid.
// A test that passes the bounding circle rotates the whole vertex ring once,
// one edge per cycle through the three-stage edge unit, and stays in S_SCAN
// until the last edge has left it; a point outside the circle skips S_SCAN.
// The ring length, not the vertex count, sets the test time.
// The next transaction can be taken in the same cycle as the result goes valid.
// The result sits in an output register; the next input is taken while it
// waits, but that item's result holds until the receiver takes the previous
// one. Reset empties the table, zeroes the center and the bounding radius;
// vertex storage itself is not cleared.
// ----------------------------------------------------------------------------
module point_in_polygon_tester_top
    import pip_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_kind,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_inside_res,
    output logic                      o_in_bounds,
    output logic                      o_table_full,
    output logic [6:0]                o_vertex_total
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_DEC  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;

    logic [1:0]                r_kind;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic signed [OFS_W-1:0]   r_dx, r_dy;
    logic [SQ_W-1:0]           r_sqx, r_sqy;
    logic [D2_W-1:0]           n_d2;
    logic [RAD_W-1:0]          r_radius;
    logic [CNT_W-1:0]          r_count;
    logic [STEP_W-1:0]         r_step;
    logic                      r_bounds, r_full;
    logic                      r_out_valid, r_out_inside, r_out_bounds, r_out_full;
    logic [6:0]                r_out_total;

    logic signed [2*OFS_W-1:0] n_px2, n_py2;

    t_vertex   w_cell [MAX_VERTICES];
    t_vertex   r_first, r_prev, w_head, w_vtx_new;
    t_edge_req w_req;
    logic      w_shift, w_add_ok, w_clear, w_parity, w_load_out;
    logic [STEP_W-1:0] w_n;

    wire w_accept = i_in_valid && o_in_ready;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_head     = w_cell[0];
    assign w_n        = STEP_W'(r_count);
    assign w_vtx_new  = '{dx: r_dx, dy: r_dy};
    assign w_add_ok   = (r_state == S_DEC) && (r_kind == KIND_ADD) &&
                        (r_count < CNT_W'(MAX_VERTICES));
    assign w_shift    = (r_state == S_SCAN) && (r_step < STEP_W'(MAX_VERTICES));
    assign w_clear    = (r_state == S_DEC);
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign n_px2 = r_dx * r_dx;
    assign n_py2 = r_dy * r_dy;
    assign n_d2  = D2_W'(r_sqx) + D2_W'(r_sqy);

    // vertex ring: cell k takes cell k+1 on a shift, the last wraps to cell 0
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
        pip_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_shift),
            .i_load     (w_add_ok && (r_count[IDX_W-1:0] == IDX_W'(k))),
            .i_load_vtx (w_vtx_new),
            .i_next_vtx (w_cell[(k + 1) % MAX_VERTICES]),
            .o_vtx      (w_cell[k])
        );
    end

    // edges (k, k-1) while vertex k is at the head, then the closing edge
    always_comb begin
        w_req.valid = (r_state == S_SCAN) && (r_step >= STEP_W'(1)) && (r_step <= w_n);
        w_req.vi    = (r_step == w_n) ? r_first : w_head;
        w_req.vj    = r_prev;
    end

    pip_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_clear),
        .i_req    (w_req),
        .i_dx     (r_dx),
        .i_dy     (r_dy),
        .o_parity (w_parity)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            if (r_step == '0) begin
                r_first <= w_head;
            end
            if (w_shift) begin
                r_prev <= w_head;
            end
        end
        if (w_accept) begin
            r_kind <= i_kind;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_dx   <= OFS_W'(i_pos_x) - OFS_W'(r_cx);
            r_dy   <= OFS_W'(i_pos_y) - OFS_W'(r_cy);
        end
        r_sqx <= SQ_W'(n_px2);
        r_sqy <= SQ_W'(n_py2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_radius    <= '0;
            r_step      <= '0;
            r_bounds    <= 1'b0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_bounds <= 1'b0;
                        r_full   <= 1'b0;
                        r_state  <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    case (r_kind)
                        KIND_ADD: begin
                            r_state <= S_DONE;
                            if (w_add_ok) begin
                                r_count <= r_count + CNT_W'(1);
                                if (RAD_W'(n_d2) > r_radius) begin
                                    r_radius <= RAD_W'(n_d2);
                                end
                            end else begin
                                r_full <= 1'b1;
                            end
                        end
                        KIND_TEST: begin
                            if (RAD_W'(n_d2) <= r_radius) begin
                                r_bounds <= 1'b1;
                                r_step   <= '0;
                                r_state  <= S_SCAN;
                            end else begin
                                r_state  <= S_DONE;
                            end
                        end
                        KIND_MOVE: begin
                            r_state <= S_DONE;
                            r_cx    <= r_px;
                            r_cy    <= r_py;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SCAN: begin
                    // hold until the last edge has left the edge pipeline
                    if (r_step == STEP_W'(SCAN_LAST)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_inside <= r_bounds && w_parity;
            r_out_bounds <= r_bounds;
            r_out_full   <= r_full;
            r_out_total  <= 7'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_inside_res   = r_out_inside;
    assign o_in_bounds    = r_out_bounds;
    assign o_table_full   = r_out_full;
    assign o_vertex_total = r_out_total;

endmodule

>>> rtl/core/pip_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_cell: one vertex slot of the circulating vertex ring
// Loads a new vertex on an add, takes its neighbor's vertex on a shift.
// ----------------------------------------------------------------------------
module pip_cell
    import pip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_shift,
    input  logic    i_load,
    input  t_vertex i_load_vtx,
    input  t_vertex i_next_vtx,
    output t_vertex o_vtx
);

    t_vertex r_vtx;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vtx <= i_load_vtx;
        end else if (i_shift) begin
            r_vtx <= i_next_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

>>> rtl/core/pip_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge: pipelined edge crossing evaluator
// Three stages: straddle test and differences, cross products, compare and
// toggle of the even-odd parity.
// ----------------------------------------------------------------------------
module pip_edge
    import pip_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  t_edge_req               i_req,
    input  logic signed [OFS_W-1:0] i_dx,
    input  logic signed [OFS_W-1:0] i_dy,
    output logic                    o_parity
);

    localparam int DIF_W = OFS_W + 1;
    localparam int PRD_W = 2 * DIF_W;

    logic signed [DIF_W-1:0] n_a, n_b, n_c, n_d;
    logic                    n_hit;
    logic                    r_v1, r_up1;
    logic signed [DIF_W-1:0] r_a, r_b, r_c, r_d;
    logic                    r_v2, r_up2;
    logic signed [PRD_W-1:0] r_lhs, r_rhs;
    logic                    r_parity;
    logic                    n_cross;

    always_comb begin
        n_hit = ((i_req.vi.dy < i_dy) && (i_req.vj.dy >= i_dy)) ||
                ((i_req.vj.dy < i_dy) && (i_req.vi.dy >= i_dy));
        n_a   = DIF_W'(i_dy) - DIF_W'(i_req.vi.dy);
        n_b   = DIF_W'(i_req.vj.dx) - DIF_W'(i_req.vi.dx);
        n_c   = DIF_W'(i_dx) - DIF_W'(i_req.vi.dx);
        n_d   = DIF_W'(i_req.vj.dy) - DIF_W'(i_req.vi.dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid && n_hit && !i_clear;
            r_v2 <= r_v1 && !i_clear;
        end
        r_up1 <= i_req.vj.dy > i_req.vi.dy;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_up2 <= r_up1;
        r_lhs <= r_a * r_b;
        r_rhs <= r_c * r_d;
    end

    // flip the inequality when the edge runs downward
    assign n_cross = r_up2 ? (r_lhs < r_rhs) : (r_lhs > r_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_clear) begin
            r_parity <= 1'b0;
        end else if (r_v2 && n_cross) begin
            r_parity <= !r_parity;
        end
    end

    assign o_parity = r_parity;

endmodule

>>> tb/tb_point_in_polygon_tester_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_tester_top: self-checking bench of the polygon tester
// Builds polygons vertex by vertex, moves the center and probes points
// around edges, vertices and the bounding circle. An in-bench predictor
// holds the vertex table and forms the expected answer of every item.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_tester_top;
    import pip_pkg::*;

    localparam int         CYCLE_LIMIT  = 2_000_000;
    localparam int         RANDOM_ITEMS = 1330;
    localparam int         HOLD_AT      = 250;
    localparam int         DRAIN_AT     = 700;
    localparam int         HOLD_CYCLES  = 600;
    localparam int         TAIL_CYCLES  = 100;
    localparam logic [1:0] KIND_NOP     = 2'd3;

    typedef struct {
        logic       in_poly;
        logic       bounds;
        logic       full;
        logic [6:0] total;
    } t_pip_answer;

    class polygon_scoreboard;
        localparam int REPORT_MAX = 10;

        longint      ofs_x [MAX_VERTICES];
        longint      ofs_y [MAX_VERTICES];
        int          stored;
        longint      ctr_x;
        longint      ctr_y;
        longint      bound_r2;
        t_pip_answer answers_due [$];
        int          mismatches;

        function new();
            stored     = 0;
            ctr_x      = 0;
            ctr_y      = 0;
            bound_r2   = 0;
            mismatches = 0;
        endfunction

        function void take_item(logic [1:0] kind, logic signed [COORD_W-1:0] px,
                                logic signed [COORD_W-1:0] py);
            longint      dx, dy, d2, xi, yi, xj, yj, lhs, rhs;
            int          j;
            bit          odd, crosses;
            t_pip_answer ans;
            dx          = longint'(px) - ctr_x;
            dy          = longint'(py) - ctr_y;
            d2          = dx * dx + dy * dy;
            ans.in_poly = 1'b0;
            ans.bounds  = 1'b0;
            ans.full    = 1'b0;
            case (kind)
                KIND_ADD: begin
                    if (stored >= MAX_VERTICES) begin
                        ans.full = 1'b1;
                    end else begin
                        ofs_x[stored] = dx;
                        ofs_y[stored] = dy;
                        stored++;
                        if (d2 > bound_r2) bound_r2 = d2;
                    end
                end
                KIND_TEST: begin
                    if (d2 <= bound_r2) begin
                        ans.bounds = 1'b1;
                        odd        = 1'b0;
                        j          = stored - 1;
                        // walk edges (i, i-1); vertex 0 pairs with the last one
                        for (int i = 0; i < stored; i++) begin
                            xi = ofs_x[i];
                            yi = ofs_y[i];
                            xj = ofs_x[j];
                            yj = ofs_y[j];
                            if ((yi < dy && yj >= dy) || (yj < dy && yi >= dy)) begin
                                lhs     = (dy - yi) * (xj - xi);
                                rhs     = (dx - xi) * (yj - yi);
                                crosses = (yj > yi) ? (lhs < rhs) : (lhs > rhs);
                                if (crosses) odd = !odd;
                            end
                            j = i;
                        end
                        ans.in_poly = odd;
                    end
                end
                KIND_MOVE: begin
                    ctr_x = longint'(px);
                    ctr_y = longint'(py);
                end
                default: ;
            endcase
            ans.total   = 7'(stored);
            answers_due = {answers_due, ans};
        endfunction

        function void check_answer(logic in_poly, logic bounds, logic full,
                                   logic [6:0] total);
            t_pip_answer want;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: inside=%b bounds=%b full=%b total=%0d",
                             in_poly, bounds, full, total);
                return;
            end
            want = answers_due.pop_front();
            if (in_poly !== want.in_poly || bounds !== want.bounds ||
                full !== want.full || total !== want.total) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: expected inside=%b bounds=%b full=%b total=%0d,",
                             want.in_poly, want.bounds, want.full, want.total,
                             " got inside=%b bounds=%b full=%b total=%0d",
                             in_poly, bounds, full, total);
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_kind      = KIND_NOP;
    logic signed [COORD_W-1:0] i_pos_x     = '0;
    logic signed [COORD_W-1:0] i_pos_y     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_inside_res;
    logic                      o_in_bounds;
    logic                      o_table_full;
    logic [6:0]                o_vertex_total;

    point_in_polygon_tester_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_inside_res   (o_inside_res),
        .o_in_bounds    (o_in_bounds),
        .o_table_full   (o_table_full),
        .o_vertex_total (o_vertex_total)
    );

    polygon_scoreboard sb;

    // stimulus-side view of the polygon, used to aim probes and pick new vertices
    longint cur_cx     = 0;
    longint cur_cy     = 0;
    longint poly_x [$];
    longint poly_y [$];
    longint poly_span  = 256;
    int     tx_burst   = 0;
    bit     hold_req   = 1'b0;
    int     hold_left  = 0;
    int     rx_phase   = 0;
    int     cycles     = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: check accepted results, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_answer(o_inside_res, o_in_bounds, o_table_full, o_vertex_total);
        if (hold_req) begin
            i_out_ready <= 1'b0;
            if (hold_left == 0) begin
                hold_left = HOLD_CYCLES;
            end else begin
                hold_left--;
                if (hold_left == 0) hold_req = 1'b0;
            end
        end else if (rx_phase > 0) begin
            rx_phase--;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            case ($urandom_range(0, 99)) inside
                [0:69]:  rx_phase = $urandom_range(0, 2);
                [70:94]: rx_phase = $urandom_range(3, 15);
                default: rx_phase = $urandom_range(40, 120);
            endcase
        end else begin
            i_out_ready <= 1'b1;
            rx_phase = ($urandom_range(0, 99) < 8) ? $urandom_range(50, 200)
                                                   : $urandom_range(0, 10);
        end
    end

    function automatic logic signed [COORD_W-1:0] to_coord(longint v);
        return v[COORD_W-1:0];
    endfunction

    function automatic longint spread(longint span);
        return longint'($urandom_range(32'(2 * span), 0)) - span;
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function int sender_gap();
        int r;
        if (tx_burst > 0) begin
            tx_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            tx_burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic send_item(logic [1:0] kind, longint x, longint y);
        int     gap;
        longint ox, oy;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_pos_x    <= to_coord(x);
        i_pos_y    <= to_coord(y);
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.take_item(kind, to_coord(x), to_coord(y));
        if (kind == KIND_ADD && poly_x.size() < MAX_VERTICES) begin
            ox = longint'(to_coord(x)) - cur_cx;
            oy = longint'(to_coord(y)) - cur_cy;
            poly_x = {poly_x, ox};
            poly_y = {poly_y, oy};
            if (abs_of(ox) > poly_span) poly_span = abs_of(ox);
            if (abs_of(oy) > poly_span) poly_span = abs_of(oy);
        end
        if (kind == KIND_MOVE) begin
            cur_cx = longint'(to_coord(x));
            cur_cy = longint'(to_coord(y));
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic pick_probe(output longint x, output longint y);
        int r, k, kk, n;
        n = poly_x.size();
        r = $urandom_range(0, 99);
        k = (n > 0) ? $urandom_range(0, n - 1) : 0;
        kk = (n > 0) ? (k + n - 1) % n : 0;
        if (n > 0 && r < 10) begin
            // on a vertex, or a hair off it
            x = cur_cx + poly_x[k] + (($urandom_range(0, 3) == 0) ? spread(1) : 0);
            y = cur_cy + poly_y[k] + (($urandom_range(0, 3) == 0) ? spread(1) : 0);
        end else if (n > 0 && r < 20) begin
            // level with a vertex
            x = cur_cx + spread(poly_span);
            y = cur_cy + poly_y[k];
        end else if (n > 1 && r < 30) begin
            x = cur_cx + (poly_x[k] + poly_x[kk]) / 2;
            y = cur_cy + (poly_y[k] + poly_y[kk]) / 2;
        end else if (r < 75) begin
            x = cur_cx + spread(poly_span);
            y = cur_cy + spread(poly_span);
        end else if (r < 88) begin
            x = cur_cx + spread(longint'(1) << 21);
            y = cur_cy + spread(longint'(1) << 21);
        end else begin
            x = spread(longint'(1) << 23);
            y = spread(longint'(1) << 23);
        end
    endtask

    task automatic pick_vertex(output longint x, output longint y);
        int     r, n;
        longint span;
        n = poly_x.size();
        r = $urandom_range(0, 99);
        if (n >= MAX_VERTICES) span = longint'(1) << 23;
        else if (n < 40)       span = (r < 90) ? 4096 : (longint'(1) << 16);
        else if (r < 70)       span = 4096;
        else if (r < 90)       span = longint'(1) << 20;
        else                   span = longint'(1) << 23;
        x = cur_cx + spread(span);
        // repeat the last y to form a horizontal edge
        if (n > 0 && $urandom_range(0, 99) < 15) y = cur_cy + poly_y[n - 1];
        else                                     y = cur_cy + spread(span);
    endtask

    initial begin
        longint px, py;
        int     r;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: only the center itself is in bounds
        send_item(KIND_TEST, 0, 0);
        send_item(KIND_TEST, 1, 0);
        send_item(KIND_NOP, 8388607, -8388608);
        send_item(KIND_NOP, -8388608, 8388607);
        // one and two vertices never cross
        send_item(KIND_ADD, 256, 0);
        send_item(KIND_TEST, 0, 0);
        send_item(KIND_ADD, 0, 256);
        send_item(KIND_TEST, 10, 10);
        // close a pentagon with two horizontal edges
        send_item(KIND_ADD, -256, 256);
        send_item(KIND_ADD, -256, -256);
        send_item(KIND_ADD, 256, -256);
        send_item(KIND_TEST, 0, 0);
        send_item(KIND_TEST, 100, 256);
        send_item(KIND_TEST, 0, 256);
        send_item(KIND_TEST, -256, 0);
        send_item(KIND_TEST, 200, 200);
        send_item(KIND_TEST, 0, -256);
        // far corners of the coordinate range
        send_item(KIND_MOVE, 8388607, 8388607);
        send_item(KIND_TEST, -8388608, -8388608);
        send_item(KIND_TEST, 8388607, 8388607);
        send_item(KIND_MOVE, -8388608, -8388608);
        send_item(KIND_TEST, -8388608, -8388608);
        send_item(KIND_TEST, -8388508, -8388508);
        send_item(KIND_MOVE, 0, 0);

        for (int n_item = 0; n_item < RANDOM_ITEMS; n_item++) begin
            // stall the receiver while items keep coming
            if (n_item == HOLD_AT) hold_req = 1'b1;
            if (n_item == DRAIN_AT) wait_idle();
            r = $urandom_range(0, 99);
            if (r < ((poly_x.size() >= MAX_VERTICES) ? 10 : 12)) begin
                pick_vertex(px, py);
                send_item(KIND_ADD, px, py);
            end else if (r < 20) begin
                if ($urandom_range(0, 99) < 70) begin
                    px = spread(longint'(1) << 16);
                    py = spread(longint'(1) << 16);
                end else begin
                    px = spread(longint'(1) << 23);
                    py = spread(longint'(1) << 23);
                end
                send_item(KIND_MOVE, px, py);
            end else if (r < 25) begin
                send_item(KIND_NOP, spread(longint'(1) << 23), spread(longint'(1) << 23));
            end else begin
                pick_probe(px, py);
                send_item(KIND_TEST, px, py);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/pip_pkg.sv
rtl/core/pip_cell.sv
rtl/core/pip_edge.sv
rtl/core/point_in_polygon_tester_top.sv
tb/tb_point_in_polygon_tester_top.sv
